// ----- design/bas_pkg.sv -----
// shared types and constants for the bitonic array search block
package bas_pkg;

  localparam int DATA_WIDTH = 31;
  localparam int POS_WIDTH  = 10;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                  op;
    logic                  restart;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                 found;
    logic [POS_WIDTH-1:0] position;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PK_CHK,
    ST_PK_A,
    ST_PK_B,
    ST_SR_CHK,
    ST_SR_CMP
  } state_t;

endpackage

// ----- design/bitonic_array_search.sv -----
// bitonic array search top level: element store, peak search and two binary searches
//
// usage
//   a command transfers at a rising edge where start is high and busy is low.
//   cmd.op selects load or search. a load writes cmd.value at the next free
//   index (or at index zero with cmd.restart, which starts a new array);
//   it produces no result. loads without restart into a full array are dropped.
//   a search looks for cmd.value in the stored mountain array: first a binary
//   search for the peak (states pk_chk, pk_a, pk_b per probe, the two neighbor
//   reads share the single ram read port), then the rising side and then the
//   falling side (states sr_chk then sr_cmp per probe, one ram read then compare);
//   busy stays high for the whole search, so one command is handled at a time.
//   the result (found, position) is presented for exactly one cycle with done
//   high, in the cycle after the search ends; the receiver cannot stall it.
//   a search on an empty array reports not found without leaving idle.
//   reset clears the element count and the controller; ram contents are left
//   as they are and are only read below the count.
module bitonic_array_search #(
  parameter int DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  bas_pkg::cmd_t   cmd,
  output logic            done,
  output bas_pkg::result_t result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = bas_pkg::DATA_WIDTH;
  localparam int PW = bas_pkg::POS_WIDTH;

  // search bounds run from -1 up to the count, so one extra sign bit
  typedef logic signed [CW:0] idx_t;

  bas_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  idx_t          lo, lo_next;
  idx_t          hi, hi_next;
  idx_t          mid, mid_next;
  idx_t          peak, peak_next;
  logic          desc, desc_next;
  logic [DW-1:0] target, target_next;
  logic [DW-1:0] va, va_next;
  logic          done_next;
  bas_pkg::result_t result_next;

  // ram ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;

  idx_t len_s;
  idx_t mid_calc;

  assign len_s    = idx_t'({1'b0, count});
  assign mid_calc = lo + ((hi - lo) >>> 1);
  assign busy     = (state != bas_pkg::ST_IDLE);

  bas_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next  = state;
    count_next  = count;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    peak_next   = peak;
    desc_next   = desc;
    target_next = target;
    va_next     = va;
    done_next   = 1'b0;
    result_next = '0;
    we          = 1'b0;
    waddr       = count[AW-1:0];
    wdata       = cmd.value;
    raddr       = mid[AW-1:0];

    unique case (state)
      bas_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd.op == bas_pkg::OP_LOAD) begin
            if (cmd.restart) begin
              we         = 1'b1;
              waddr      = '0;
              count_next = CW'(1);
            end else if (count < CW'(DEPTH)) begin
              we         = 1'b1;
              count_next = count + CW'(1);
            end
          end else begin
            target_next = cmd.value;
            if (count == '0) begin
              // empty array: not found straight away
              done_next = 1'b1;
            end else begin
              lo_next    = idx_t'(1);
              hi_next    = len_s - idx_t'(2);
              peak_next  = '0;
              state_next = bas_pkg::ST_PK_CHK;
            end
          end
        end
      end

      // peak search: probe mid and mid+1, read of mid issued here
      bas_pkg::ST_PK_CHK: begin
        if (lo <= hi) begin
          mid_next   = mid_calc;
          raddr      = mid_calc[AW-1:0];
          state_next = bas_pkg::ST_PK_A;
        end else begin
          lo_next    = '0;
          hi_next    = peak;
          desc_next  = 1'b0;
          state_next = bas_pkg::ST_SR_CHK;
        end
      end

      bas_pkg::ST_PK_A: begin
        // mid is on rdata, fetch its right neighbor
        va_next    = rdata;
        raddr      = AW'(mid + idx_t'(1));
        state_next = bas_pkg::ST_PK_B;
      end

      bas_pkg::ST_PK_B: begin
        // still rising: peak lies to the right
        if (va < rdata) begin
          lo_next = mid + idx_t'(1);
        end else begin
          peak_next = mid;
          hi_next   = mid - idx_t'(1);
        end
        state_next = bas_pkg::ST_PK_CHK;
      end

      bas_pkg::ST_SR_CHK: begin
        if (lo <= hi) begin
          mid_next   = mid_calc;
          raddr      = mid_calc[AW-1:0];
          state_next = bas_pkg::ST_SR_CMP;
        end else if (!desc) begin
          lo_next   = peak + idx_t'(1);
          hi_next   = len_s - idx_t'(1);
          desc_next = 1'b1;
        end else begin
          done_next  = 1'b1;
          state_next = bas_pkg::ST_IDLE;
        end
      end

      bas_pkg::ST_SR_CMP: begin
        if (rdata == target) begin
          done_next            = 1'b1;
          result_next.found    = 1'b1;
          result_next.position = PW'(mid);
          state_next           = bas_pkg::ST_IDLE;
        end else if ((rdata < target) != desc) begin
          lo_next    = mid + idx_t'(1);
          state_next = bas_pkg::ST_SR_CHK;
        end else begin
          hi_next    = mid - idx_t'(1);
          state_next = bas_pkg::ST_SR_CHK;
        end
      end

      default: begin
        state_next = bas_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bas_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    peak   <= peak_next;
    desc   <= desc_next;
    target <= target_next;
    va     <= va_next;
    result <= result_next;
  end

endmodule

// ----- design/bas_ram.sv -----
// generic single-clock ram, one write port, one registered read port
module bas_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
